>>> rtl/core/ppt_pkg.sv
package ppt_pkg;

  localparam int unsigned SlotsDef      = 64;
  localparam int unsigned WordWidthDef  = 32;
  localparam int unsigned PrioWidthDef  = 24;
  localparam int unsigned StampW        = 32;
  localparam int unsigned ModeW         = 3;
  localparam int unsigned StatusW       = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD      = 3'd0,
    MODE_PROMOTE  = 3'd1,
    MODE_GET      = 3'd2,
    MODE_IS_VALID = 3'd3,
    MODE_GET_MAX  = 3'd4,
    MODE_POP_MAX  = 3'd5
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WORD,
    S_SEND
  } state_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ADD,
    WR_PROMOTE,
    WR_CLEAR
  } wr_kind_e;

  // control part of the token that walks the cell row
  typedef struct packed {
    logic valid;
    logic best_found;
    logic free_found;
    logic hit_valid;
  } tok_ctl_t;

endpackage

>>> rtl/core/ppt_if.sv
interface ppt_req_if #(
  parameter int unsigned ID_W   = 6,
  parameter int unsigned WORD_W = 32
);
  logic                       valid;
  logic                       ready;
  logic [ppt_pkg::ModeW-1:0]  mode;
  logic [ID_W-1:0]            slot_id;
  logic [WORD_W-1:0]          data_word;

  modport source (output valid, mode, slot_id, data_word, input ready);
  modport sink   (input valid, mode, slot_id, data_word, output ready);
endinterface

interface ppt_rsp_if #(
  parameter int unsigned ID_W   = 6,
  parameter int unsigned WORD_W = 32,
  parameter int unsigned PRIO_W = 24
);
  logic                         valid;
  logic                         ready;
  logic [ID_W-1:0]              result_id;
  logic [WORD_W-1:0]            result_word;
  logic [PRIO_W-1:0]            result_priority;
  logic                         id_valid;
  logic [ppt_pkg::StatusW-1:0]  status;

  modport source (output valid, result_id, result_word, result_priority, id_valid, status,
                  input ready);
  modport sink   (input valid, result_id, result_word, result_priority, id_valid, status,
                  output ready);
endinterface

>>> rtl/core/ppt_ram.sv
module ppt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/core/ppt_cell.sv
module ppt_cell #(
  parameter int unsigned ID_W   = 6,
  parameter int unsigned PRIO_W = 24,
  parameter int unsigned INDEX  = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ppt_pkg::StampW-1:0]   stamp_now_i,
  input  logic [ID_W-1:0]              tgt_id_i,
  input  ppt_pkg::wr_kind_e            wr_kind_i,
  input  logic [ID_W-1:0]              wr_id_i,
  input  ppt_pkg::tok_ctl_t            ctl_i,
  input  logic [PRIO_W-1:0]            best_prio_i,
  input  logic [ppt_pkg::StampW-1:0]   best_age_i,
  input  logic [ID_W-1:0]              best_id_i,
  input  logic [ID_W-1:0]              free_id_i,
  input  logic [PRIO_W-1:0]            hit_prio_i,
  output ppt_pkg::tok_ctl_t            ctl_o,
  output logic [PRIO_W-1:0]            best_prio_o,
  output logic [ppt_pkg::StampW-1:0]   best_age_o,
  output logic [ID_W-1:0]              best_id_o,
  output logic [ID_W-1:0]              free_id_o,
  output logic [PRIO_W-1:0]            hit_prio_o
);
  localparam logic [ID_W-1:0]   MyId    = ID_W'(INDEX);
  localparam logic [PRIO_W-1:0] PrioMax = '1;

  logic                       valid_q;
  logic [PRIO_W-1:0]          prio_q;
  logic [ppt_pkg::StampW-1:0] stamp_q;
  logic [ppt_pkg::StampW-1:0] age;
  logic                       take_best, take_free, is_tgt, wr_hit;

  ppt_pkg::tok_ctl_t          ctl_d, ctl_q;
  logic [PRIO_W-1:0]          best_prio_d, best_prio_q, hit_prio_d, hit_prio_q;
  logic [ppt_pkg::StampW-1:0] best_age_d, best_age_q;
  logic [ID_W-1:0]            best_id_d, best_id_q, free_id_d, free_id_q;

  assign wr_hit = (wr_id_i == MyId);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prio_q  <= '0;
    end else if (wr_hit) begin
      case (wr_kind_i)
        ppt_pkg::WR_ADD: begin
          valid_q <= 1'b1;
          prio_q  <= '0;
        end
        ppt_pkg::WR_PROMOTE: begin
          if (prio_q != PrioMax) prio_q <= prio_q + 1'b1;
        end
        ppt_pkg::WR_CLEAR: begin
          valid_q <= 1'b0;
          prio_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit && wr_kind_i == ppt_pkg::WR_ADD) stamp_q <= stamp_now_i;
  end

  assign age       = stamp_now_i - stamp_q;
  assign take_best = valid_q && (!ctl_i.best_found || prio_q > best_prio_i ||
                     (prio_q == best_prio_i && age < best_age_i));
  assign take_free = !valid_q && !ctl_i.free_found;
  assign is_tgt    = (tgt_id_i == MyId);

  always_comb begin
    ctl_d       = ctl_i;
    best_prio_d = best_prio_i;
    best_age_d  = best_age_i;
    best_id_d   = best_id_i;
    free_id_d   = free_id_i;
    hit_prio_d  = hit_prio_i;
    if (take_best) begin
      ctl_d.best_found = 1'b1;
      best_prio_d      = prio_q;
      best_age_d       = age;
      best_id_d        = MyId;
    end
    if (take_free) begin
      ctl_d.free_found = 1'b1;
      free_id_d        = MyId;
    end
    if (is_tgt) begin
      ctl_d.hit_valid = valid_q;
      hit_prio_d      = prio_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_prio_q <= best_prio_d;
    best_age_q  <= best_age_d;
    best_id_q   <= best_id_d;
    free_id_q   <= free_id_d;
    hit_prio_q  <= hit_prio_d;
  end

  assign ctl_o       = ctl_q;
  assign best_prio_o = best_prio_q;
  assign best_age_o  = best_age_q;
  assign best_id_o   = best_id_q;
  assign free_id_o   = free_id_q;
  assign hit_prio_o  = hit_prio_q;
endmodule

>>> rtl/core/promotable_priority_table.sv
// Promotable priority table: SLOTS slots of word, priority, valid mark and stamp.
// Request channel req_i carries mode, slot_id and data_word; response channel rsp_o
// carries result_id, result_word, result_priority, id_valid and status, one response
// per request, in order.
// Every request walks a token down a row of SLOTS cells, one cell per cycle; each cell
// folds its slot into the running maximum, the lowest free slot and the addressed-slot
// lookup. From acceptance to response valid a request passes the row, the word memory
// read and the load of the response register, in that order; one request is worked
// on at a time, so a new request is taken only once the last one has been loaded into
// the response register. Table updates (add, promote, pop) land at the end of the
// walk. Words sit in a SLOTS-deep memory with registered read.
// Reset clears all valid marks, priorities and the stamp counter; the table is then
// empty and ready at once. The response register holds its item while rsp_o.ready is
// low; a new request may be taken meanwhile and finishes its walk, then waits until
// the response register frees up.
module promotable_priority_table #(
  parameter int unsigned SLOTS          = ppt_pkg::SlotsDef,
  parameter int unsigned WORD_WIDTH     = ppt_pkg::WordWidthDef,
  parameter int unsigned PRIORITY_WIDTH = ppt_pkg::PrioWidthDef,
  parameter int unsigned ID_W           = $clog2(SLOTS)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppt_req_if.sink    req_i,
  ppt_rsp_if.source  rsp_o
);
  localparam int unsigned SW = ppt_pkg::StampW;
  localparam logic [PRIORITY_WIDTH-1:0] PrioMax = '1;

  ppt_pkg::state_e state_q, state_d;

  logic [ppt_pkg::ModeW-1:0] mode_q;
  logic [ID_W-1:0]           slot_q;
  logic [WORD_WIDTH-1:0]     word_q;
  logic [SW-1:0]             stamp_q;

  // chain links: link i feeds cell i
  ppt_pkg::tok_ctl_t         ctl_l   [SLOTS+1];
  logic [PRIORITY_WIDTH-1:0] bprio_l [SLOTS+1];
  logic [SW-1:0]             bage_l  [SLOTS+1];
  logic [ID_W-1:0]           bid_l   [SLOTS+1];
  logic [ID_W-1:0]           fid_l   [SLOTS+1];
  logic [PRIORITY_WIDTH-1:0] hprio_l [SLOTS+1];

  ppt_pkg::tok_ctl_t         exit_ctl;
  ppt_pkg::wr_kind_e         wr_kind;
  logic [ID_W-1:0]           wr_id;
  logic                      in_fire, exit_fire, add_fire, ram_we;
  logic [ID_W-1:0]           ram_raddr;
  logic [WORD_WIDTH-1:0]     ram_rdata;

  logic                         pend_need_word_q, pend_need_word_d;
  logic [ID_W-1:0]              pend_id_q, pend_id_d;
  logic [WORD_WIDTH-1:0]        pend_word_q, pend_word_d;
  logic [PRIORITY_WIDTH-1:0]    pend_prio_q, pend_prio_d;
  logic                         pend_idv_q, pend_idv_d;
  logic [ppt_pkg::StatusW-1:0]  pend_st_q, pend_st_d;

  logic                         out_valid_q, out_load;
  logic [ID_W-1:0]              out_id_q;
  logic [WORD_WIDTH-1:0]        out_word_q;
  logic [PRIORITY_WIDTH-1:0]    out_prio_q;
  logic                         out_idv_q;
  logic [ppt_pkg::StatusW-1:0]  out_st_q;

  assign req_i.ready = (state_q == ppt_pkg::S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= req_i.mode;
      slot_q <= req_i.slot_id;
      word_q <= req_i.data_word;
    end
  end

  // inject a fresh token into the head of the row
  always_comb begin
    ctl_l[0]       = '0;
    ctl_l[0].valid = in_fire;
    bprio_l[0]     = '0;
    bage_l[0]      = '0;
    bid_l[0]       = '0;
    fid_l[0]       = '0;
    hprio_l[0]     = '0;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ppt_cell #(
      .ID_W  (ID_W),
      .PRIO_W(PRIORITY_WIDTH),
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stamp_now_i(stamp_q),
      // the head cell sees the token in the accepting cycle, before slot_q loads
      .tgt_id_i   ((i == 0) ? req_i.slot_id : slot_q),
      .wr_kind_i  (wr_kind),
      .wr_id_i    (wr_id),
      .ctl_i      (ctl_l[i]),
      .best_prio_i(bprio_l[i]),
      .best_age_i (bage_l[i]),
      .best_id_i  (bid_l[i]),
      .free_id_i  (fid_l[i]),
      .hit_prio_i (hprio_l[i]),
      .ctl_o      (ctl_l[i+1]),
      .best_prio_o(bprio_l[i+1]),
      .best_age_o (bage_l[i+1]),
      .best_id_o  (bid_l[i+1]),
      .free_id_o  (fid_l[i+1]),
      .hit_prio_o (hprio_l[i+1])
    );
  end

  assign exit_ctl  = ctl_l[SLOTS];
  assign exit_fire = (state_q == ppt_pkg::S_SCAN) && exit_ctl.valid;

  ppt_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(SLOTS)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fid_l[SLOTS]),
    .wdata_i(word_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // resolve the request when the token leaves the row
  always_comb begin
    wr_kind          = ppt_pkg::WR_NONE;
    wr_id            = slot_q;
    ram_raddr        = slot_q;
    ram_we           = 1'b0;
    add_fire         = 1'b0;
    pend_need_word_d = pend_need_word_q;
    pend_id_d        = pend_id_q;
    pend_word_d      = pend_word_q;
    pend_prio_d      = pend_prio_q;
    pend_idv_d       = pend_idv_q;
    pend_st_d        = pend_st_q;
    if (exit_fire) begin
      pend_need_word_d = 1'b0;
      pend_id_d        = '0;
      pend_word_d      = '0;
      pend_prio_d      = '0;
      pend_idv_d       = 1'b0;
      pend_st_d        = ppt_pkg::ST_OK;
      unique case (mode_q)
        ppt_pkg::MODE_ADD: begin
          if (exit_ctl.free_found) begin
            wr_kind    = ppt_pkg::WR_ADD;
            wr_id      = fid_l[SLOTS];
            ram_we     = 1'b1;
            add_fire   = 1'b1;
            pend_id_d  = fid_l[SLOTS];
            pend_idv_d = 1'b1;
          end else begin
            pend_st_d = ppt_pkg::ST_FULL;
          end
        end
        ppt_pkg::MODE_PROMOTE: begin
          pend_id_d = slot_q;
          if (exit_ctl.hit_valid) begin
            wr_kind     = ppt_pkg::WR_PROMOTE;
            pend_idv_d  = 1'b1;
            pend_prio_d = (hprio_l[SLOTS] == PrioMax) ? hprio_l[SLOTS]
                                                      : hprio_l[SLOTS] + 1'b1;
          end else begin
            pend_st_d = ppt_pkg::ST_BAD_ID;
          end
        end
        ppt_pkg::MODE_GET: begin
          pend_id_d = slot_q;
          if (exit_ctl.hit_valid) begin
            pend_need_word_d = 1'b1;
            pend_idv_d       = 1'b1;
            pend_prio_d      = hprio_l[SLOTS];
          end else begin
            pend_st_d = ppt_pkg::ST_BAD_ID;
          end
        end
        ppt_pkg::MODE_IS_VALID: begin
          pend_id_d  = slot_q;
          pend_idv_d = exit_ctl.hit_valid;
        end
        ppt_pkg::MODE_GET_MAX, ppt_pkg::MODE_POP_MAX: begin
          if (exit_ctl.best_found) begin
            ram_raddr        = bid_l[SLOTS];
            pend_need_word_d = 1'b1;
            pend_id_d        = bid_l[SLOTS];
            pend_idv_d       = 1'b1;
            pend_prio_d      = bprio_l[SLOTS];
            if (mode_q == ppt_pkg::MODE_POP_MAX) begin
              wr_kind = ppt_pkg::WR_CLEAR;
              wr_id   = bid_l[SLOTS];
            end
          end else begin
            pend_st_d = ppt_pkg::ST_EMPTY;
          end
        end
        default: ;
      endcase
    end else if (state_q == ppt_pkg::S_WORD && pend_need_word_q) begin
      pend_word_d = ram_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_need_word_q <= pend_need_word_d;
    pend_id_q        <= pend_id_d;
    pend_word_q      <= pend_word_d;
    pend_prio_q      <= pend_prio_d;
    pend_idv_q       <= pend_idv_d;
    pend_st_q        <= pend_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
    end else if (add_fire) begin
      stamp_q <= stamp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ppt_pkg::S_IDLE: if (in_fire) state_d = ppt_pkg::S_SCAN;
      ppt_pkg::S_SCAN: if (exit_ctl.valid) state_d = ppt_pkg::S_WORD;
      ppt_pkg::S_WORD: state_d = ppt_pkg::S_SEND;
      ppt_pkg::S_SEND: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ppt_pkg::S_IDLE;
        end
      end
      default: state_d = ppt_pkg::S_IDLE;
    endcase
  end

  // response register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q   <= pend_id_q;
      out_word_q <= pend_word_q;
      out_prio_q <= pend_prio_q;
      out_idv_q  <= pend_idv_q;
      out_st_q   <= pend_st_q;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.result_id       = out_id_q;
  assign rsp_o.result_word     = out_word_q;
  assign rsp_o.result_priority = out_prio_q;
  assign rsp_o.id_valid        = out_idv_q;
  assign rsp_o.status          = out_st_q;

  a_exit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_ctl.valid |-> state_q == ppt_pkg::S_SCAN)
    else $error("token left the row outside a scan");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ppt_pkg::S_SCAN && ctl_l[1].valid)
    else $error("accepted item did not enter the row");

  a_stamp_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(stamp_q) |-> $past(add_fire))
    else $error("stamp counter moved without an add");

  a_load_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || rsp_o.ready)
    else $error("response register overwritten while held");
endmodule
